FILE: design/db_response_packet_parser_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the response packet parser.
// The real forms hold concurrent assertions; with SYNTH set they vanish.
// ---------------------------------------------------------------------------
`ifndef DB_RESPONSE_PACKET_PARSER_MACROS_SVH
`define DB_RESPONSE_PACKET_PARSER_MACROS_SVH

`ifndef SYNTH
// prop holds at every clock edge out of reset
`define DBRPP_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// cond never holds at a clock edge out of reset
`define DBRPP_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define DBRPP_ASSERT(label, clk, rstn, prop, msg)
`define DBRPP_NEVER(label, clk, rstn, cond, msg)
`endif

`endif

FILE: design/dbrpp_pkg.sv
// ---------------------------------------------------------------------------
// dbrpp_pkg
// Shared types, codes and the packet classification function.
// ---------------------------------------------------------------------------
package dbrpp_pkg;

    // packet classes
    localparam logic [1:0] KIND_OK    = 2'd0;
    localparam logic [1:0] KIND_EOF   = 2'd1;
    localparam logic [1:0] KIND_DATA  = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_SERVER   = 2'd1;
    localparam logic [1:0] ERR_PROTOCOL = 2'd2;
    localparam logic [1:0] ERR_EXPECT   = 2'd3;

    // expect_mode values
    localparam logic [1:0] MODE_OK      = 2'd0;
    localparam logic [1:0] MODE_DATA    = 2'd1;
    localparam logic [1:0] MODE_BOTH    = 2'd2;
    localparam logic [1:0] MODE_INVALID = 2'd3;
    localparam logic [1:0] MODE_RESET   = MODE_BOTH;

    // class bytes
    localparam logic [7:0] BYTE_OK  = 8'h00;
    localparam logic [7:0] BYTE_EOF = 8'hFE;
    localparam logic [7:0] BYTE_ERR = 8'hFF;

    // length-coded integer lead bytes
    localparam logic [7:0] LENC_NULL = 8'd251;
    localparam logic [7:0] LENC_2    = 8'd252;
    localparam logic [7:0] LENC_3    = 8'd253;
    localparam logic [7:0] LENC_8    = 8'd254;

    // header layout
    localparam int unsigned HDR_BYTES = 4;
    localparam logic [23:0] MAX_PROTO_ERR_LEN = 24'd3;

    // register map
    localparam logic REG_EXPECT_MODE = 1'b0;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  error_code;
        logic [23:0] payload_length;
        logic [7:0]  sequence_number;
        logic [63:0] rows_changed;
        logic [63:0] last_id;
        logic [15:0] server_status;
        logic [15:0] warning_count;
    } result_t;

    function automatic result_t dbrpp_classify(
        input logic [7:0]  fb,
        input logic [1:0]  mode,
        input logic [23:0] len,
        input logic [7:0]  seq,
        input logic [63:0] rows,
        input logic [63:0] id,
        input logic [15:0] status,
        input logic [15:0] warn
    );
        result_t r;
        logic    is_ok;
        logic    is_eof;
        r      = '0;
        is_ok  = 1'b0;
        is_eof = 1'b0;
        r.kind = KIND_ERROR;
        r.error_code = ERR_NONE;
        if (fb == BYTE_ERR) begin
            r.error_code = (len > MAX_PROTO_ERR_LEN) ? ERR_SERVER : ERR_PROTOCOL;
        end else if ((mode == MODE_OK || mode == MODE_BOTH) && fb == BYTE_OK) begin
            r.kind = KIND_OK;
            is_ok  = 1'b1;
        end else if (mode == MODE_DATA || mode == MODE_BOTH) begin
            if (fb == BYTE_EOF) begin
                r.kind = KIND_EOF;
                is_eof = 1'b1;
            end else begin
                r.kind = KIND_DATA;
            end
        end else begin
            r.error_code = ERR_EXPECT;
        end
        r.payload_length  = len;
        r.sequence_number = seq;
        r.rows_changed    = is_ok ? rows : 64'd0;
        r.last_id         = is_ok ? id : 64'd0;
        r.server_status   = (is_ok || is_eof) ? status : 16'd0;
        r.warning_count   = (is_ok || is_eof) ? warn : 16'd0;
        return r;
    endfunction

endpackage

FILE: design/dbrpp_parser.sv
// ---------------------------------------------------------------------------
// dbrpp_parser
// Per-byte packet state: header capture, OK/EOF field extraction, result.
// ---------------------------------------------------------------------------
module dbrpp_parser
    import dbrpp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step_en,
    input  logic [7:0] step_byte,
    input  logic [1:0] expect_mode,
    output logic       res_vld,
    output result_t    res
);

    // OK-parse steps
    localparam logic [2:0] STEP_ROWS_LEAD  = 3'd0;
    localparam logic [2:0] STEP_ROWS_EXTRA = 3'd1;
    localparam logic [2:0] STEP_ID_LEAD    = 3'd2;
    localparam logic [2:0] STEP_ID_EXTRA   = 3'd3;
    localparam logic [2:0] STEP_STATUS     = 3'd4;
    localparam logic [2:0] STEP_WARN       = 3'd5;
    localparam logic [2:0] STEP_DONE       = 3'd6;

    localparam logic PH_HEADER  = 1'b0;
    localparam logic PH_PAYLOAD = 1'b1;

    localparam logic [23:0] SEQ_POS = 24'(HDR_BYTES - 1);

    logic        phase_reg,   phase_next;
    logic [23:0] pos_reg,     pos_next;
    logic [23:0] len_reg,     len_next;
    logic [7:0]  seq_reg,     seq_next;
    logic [7:0]  fb_reg,      fb_next;
    logic [2:0]  step_reg,    step_next;
    logic [3:0]  left_reg,    left_next;
    logic [2:0]  idx_reg,     idx_next;
    logic [63:0] rows_reg,    rows_next;
    logic [63:0] id_reg,      id_next;
    logic [15:0] status_reg,  status_next;
    logic [15:0] warn_reg,    warn_next;

    always_comb begin
        logic [23:0] pos_inc;
        logic [3:0]  left_dec;
        logic [7:0]  lead_val;
        logic        emit;
        logic [7:0]  fb_emit;
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        len_next    = len_reg;
        seq_next    = seq_reg;
        fb_next     = fb_reg;
        step_next   = step_reg;
        left_next   = left_reg;
        idx_next    = idx_reg;
        rows_next   = rows_reg;
        id_next     = id_reg;
        status_next = status_reg;
        warn_next   = warn_reg;
        pos_inc     = pos_reg + 24'd1;
        left_dec    = (left_reg != 4'd0) ? left_reg - 4'd1 : 4'd0;
        lead_val    = (step_byte < LENC_NULL) ? step_byte : 8'd0;
        emit        = 1'b0;
        fb_emit     = fb_reg;

        if (phase_reg == PH_HEADER) begin
            if (pos_reg != SEQ_POS) begin
                case (pos_reg[1:0])
                    2'd0:    len_next = {16'd0, step_byte};
                    2'd1:    len_next[15:8] = step_byte;
                    default: len_next[23:16] = step_byte;
                endcase
                pos_next = pos_inc;
            end else begin
                seq_next    = step_byte;
                pos_next    = '0;
                fb_next     = '0;
                step_next   = STEP_ROWS_LEAD;
                left_next   = '0;
                idx_next    = '0;
                rows_next   = '0;
                id_next     = '0;
                status_next = '0;
                warn_next   = '0;
                if (len_reg == 24'd0) begin
                    // empty packet reads as a short error packet
                    emit    = 1'b1;
                    fb_emit = BYTE_ERR;
                end else begin
                    phase_next = PH_PAYLOAD;
                end
            end
        end else begin
            if (pos_reg == 24'd0) begin
                fb_next = step_byte;
            end else if (fb_reg == BYTE_OK) begin
                case (step_reg)
                    STEP_ROWS_LEAD, STEP_ID_LEAD: begin
                        if (step_byte == LENC_2 || step_byte == LENC_3 ||
                            step_byte == LENC_8) begin
                            left_next = (step_byte == LENC_2) ? 4'd2 :
                                        (step_byte == LENC_3) ? 4'd3 : 4'd8;
                            idx_next  = '0;
                            step_next = step_reg + 3'd1;
                        end else begin
                            if (step_reg == STEP_ROWS_LEAD) begin
                                rows_next = {56'd0, lead_val};
                                step_next = STEP_ID_LEAD;
                            end else begin
                                id_next   = {56'd0, lead_val};
                                step_next = STEP_STATUS;
                                left_next = 4'd2;
                                idx_next  = '0;
                            end
                        end
                    end
                    STEP_ROWS_EXTRA, STEP_ID_EXTRA: begin
                        if (step_reg == STEP_ROWS_EXTRA) begin
                            rows_next[{idx_reg, 3'b000} +: 8] =
                                rows_reg[{idx_reg, 3'b000} +: 8] | step_byte;
                        end else begin
                            id_next[{idx_reg, 3'b000} +: 8] =
                                id_reg[{idx_reg, 3'b000} +: 8] | step_byte;
                        end
                        idx_next  = idx_reg + 3'd1;
                        left_next = left_dec;
                        if (left_dec == 4'd0) begin
                            step_next = step_reg + 3'd1;
                            if (step_reg == STEP_ID_EXTRA) begin
                                left_next = 4'd2;
                                idx_next  = '0;
                            end
                        end
                    end
                    STEP_STATUS, STEP_WARN: begin
                        if (step_reg == STEP_STATUS) begin
                            status_next[{idx_reg[0], 3'b000} +: 8] =
                                status_reg[{idx_reg[0], 3'b000} +: 8] | step_byte;
                        end else begin
                            warn_next[{idx_reg[0], 3'b000} +: 8] =
                                warn_reg[{idx_reg[0], 3'b000} +: 8] | step_byte;
                        end
                        idx_next  = idx_reg + 3'd1;
                        left_next = left_dec;
                        if (left_dec == 4'd0) begin
                            step_next = step_reg + 3'd1;
                            if (step_reg == STEP_STATUS) begin
                                left_next = 4'd2;
                                idx_next  = '0;
                            end
                        end
                    end
                    default: ;
                endcase
            end else if (fb_reg == BYTE_EOF) begin
                // EOF body: warnings, then status
                case (pos_reg)
                    24'd1:   warn_next[7:0]    = step_byte;
                    24'd2:   warn_next[15:8]   = step_byte;
                    24'd3:   status_next[7:0]  = step_byte;
                    24'd4:   status_next[15:8] = step_byte;
                    default: ;
                endcase
            end

            pos_next = pos_inc;
            if (pos_inc == len_reg) begin
                emit       = 1'b1;
                fb_emit    = fb_next;
                phase_next = PH_HEADER;
                pos_next   = '0;
            end
        end

        res_vld = step_en && emit;
        res     = dbrpp_classify(fb_emit, expect_mode, len_reg, seq_next,
                                 rows_next, id_next, status_next, warn_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEADER;
            pos_reg    <= '0;
            len_reg    <= '0;
            seq_reg    <= '0;
            fb_reg     <= '0;
            step_reg   <= STEP_ROWS_LEAD;
            left_reg   <= '0;
            idx_reg    <= '0;
            rows_reg   <= '0;
            id_reg     <= '0;
            status_reg <= '0;
            warn_reg   <= '0;
        end else if (step_en) begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            len_reg    <= len_next;
            seq_reg    <= seq_next;
            fb_reg     <= fb_next;
            step_reg   <= step_next;
            left_reg   <= left_next;
            idx_reg    <= idx_next;
            rows_reg   <= rows_next;
            id_reg     <= id_next;
            status_reg <= status_next;
            warn_reg   <= warn_next;
        end
    end

endmodule

FILE: design/db_response_packet_parser.sv
// ---------------------------------------------------------------------------
// db_response_packet_parser
// Splits a database response byte stream into packets and reports each one.
// ---------------------------------------------------------------------------
// Usage:
//  - s_ channel: one stream byte per word (s_in_byte), headers and payloads
//    back to back. Each packet is a 4-byte header (24-bit little-endian
//    length, sequence byte) followed by its payload.
//  - m_ channel: one result word per packet, sent for the packet's last
//    byte (for an empty packet, for its sequence byte).
//  - APB port: expect_mode at address 0, written by the user only while the block idles; not enforced by the block.
//  - Result: m_valid rises once a packet's last byte has passed from the input
//    register through the parse step into the result register.
//  - Throughput: one byte per cycle while no held result stalls the input,
//    set by the combinational parse step between the input and result registers.
//  - Stall: while m_ready is low with a result held, the byte in the input
//    register waits and s_ready drops once it is occupied.
//  - Reset: clears the parse state to the header phase, empties both
//    registers and sets expect_mode to 2 (OK and data both accepted).
// ---------------------------------------------------------------------------
`include "db_response_packet_parser_macros.svh"

module db_response_packet_parser
    import dbrpp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    // byte stream in
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,

    // packet results out
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [1:0]  m_error_code,
    output logic [23:0] m_payload_length,
    output logic [7:0]  m_sequence_number,
    output logic [63:0] m_rows_changed,
    output logic [63:0] m_last_id,
    output logic [15:0] m_server_status,
    output logic [15:0] m_warning_count,

    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic [1:0] mode_reg;
    logic       out_vld_reg;
    result_t    out_reg;

    logic       step_en;
    logic       res_vld;
    result_t    res;

    // ---- configuration port: one register, no wait states ----
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_EXPECT_MODE) ? {30'd0, mode_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_RESET;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == REG_EXPECT_MODE) begin
            mode_reg <= pwdata[1:0];
        end
    end

    // ---- input register ----
    // The held byte is parsed when the result register is free or draining,
    // so a new byte can enter every cycle while the output keeps up.
    assign step_en = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || step_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
        end
    end

    // ---- parse step ----
    dbrpp_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (step_en),
        .step_byte   (in_byte_reg),
        .expect_mode (mode_reg),
        .res_vld     (res_vld),
        .res         (res)
    );

    // ---- result register ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (res_vld) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_vld) begin
            out_reg <= res;
        end
    end

    assign m_valid           = out_vld_reg;
    assign m_kind            = out_reg.kind;
    assign m_error_code      = out_reg.error_code;
    assign m_payload_length  = out_reg.payload_length;
    assign m_sequence_number = out_reg.sequence_number;
    assign m_rows_changed    = out_reg.rows_changed;
    assign m_last_id         = out_reg.last_id;
    assign m_server_status   = out_reg.server_status;
    assign m_warning_count   = out_reg.warning_count;

    // ---- checks ----
    // a produced result is on the output the next cycle
    `DBRPP_ASSERT(a_res_lands, aclk, aresetn, res_vld |=> m_valid, "result lost")
    // a result is never produced over one still waiting
    `DBRPP_NEVER(a_no_overwrite, aclk, aresetn, res_vld && out_vld_reg && !m_ready, "result overwritten")
    // only error results carry an error code
    `DBRPP_ASSERT(a_err_kind, aclk, aresetn, (m_valid && m_error_code != ERR_NONE) |-> (m_kind == KIND_ERROR), "error code on non-error kind")
    // protocol errors come only from short packets
    `DBRPP_ASSERT(a_proto_len, aclk, aresetn, (m_valid && m_error_code == ERR_PROTOCOL) |-> (m_payload_length <= MAX_PROTO_ERR_LEN), "protocol error on long packet")
    // OK-only counters stay clear on every other kind
    `DBRPP_ASSERT(a_ok_fields, aclk, aresetn, (m_valid && m_kind != KIND_OK) |-> (m_rows_changed == 64'd0 && m_last_id == 64'd0), "OK fields on non-OK result")

endmodule

FILE: verif/db_response_packet_parser_test.sv
// ---------------------------------------------------------------------------
// db_response_packet_parser_test
// Feeds whole response packets through the parser one byte per word and
// checks every result word against a local parse of the same stream, under
// every expect_mode setting.
// ---------------------------------------------------------------------------
module db_response_packet_parser_test;
    import dbrpp_pkg::*;

    localparam int          WATCHDOG_LIMIT   = 2000;
    // extra settling time once the stream and the result queue are empty
    localparam int          DRAIN_CYCLES     = 8;
    localparam logic [2:0]  EXPECT_MODE_ADDR = {REG_EXPECT_MODE, 2'b00};

    // OK payload parse steps
    localparam logic [2:0]  STEP_ROWS_LEAD = 3'd0;
    localparam logic [2:0]  STEP_ROWS_EXT  = 3'd1;
    localparam logic [2:0]  STEP_ID_LEAD   = 3'd2;
    localparam logic [2:0]  STEP_ID_EXT    = 3'd3;
    localparam logic [2:0]  STEP_STATUS    = 3'd4;
    localparam logic [2:0]  STEP_WARN      = 3'd5;

    // length-coded integer encodings used when building OK payloads
    localparam int          CODE_DIRECT = 0;
    localparam int          CODE_NULL   = 1;
    localparam int          CODE_UNUSED = 2;   // lead byte 255, reads as zero
    localparam int          CODE_TWO    = 3;
    localparam int          CODE_THREE  = 4;
    localparam int          CODE_EIGHT  = 5;

    // -----------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // -----------------------------------------------------------------------
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_byte = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic [1:0]  m_kind;
    logic [1:0]  m_error_code;
    logic [23:0] m_payload_length;
    logic [7:0]  m_sequence_number;
    logic [63:0] m_rows_changed;
    logic [63:0] m_last_id;
    logic [15:0] m_server_status;
    logic [15:0] m_warning_count;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    always #6 aclk = ~aclk;

    db_response_packet_parser u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_in_byte         (s_in_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_kind            (m_kind),
        .m_error_code      (m_error_code),
        .m_payload_length  (m_payload_length),
        .m_sequence_number (m_sequence_number),
        .m_rows_changed    (m_rows_changed),
        .m_last_id         (m_last_id),
        .m_server_status   (m_server_status),
        .m_warning_count   (m_warning_count),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    // -----------------------------------------------------------------------
    // Bookkeeping
    // -----------------------------------------------------------------------
    logic [7:0]  stream_bytes[$];      // bytes waiting for the sender
    logic [7:0]  pkt[$];               // payload under construction
    result_t     pending_reports[$];   // predicted result words, oldest first
    result_t     want_report;

    int          fail_count   = 0;
    int          bytes_queued = 0;
    int          bytes_taken  = 0;
    int          reports_seen = 0;
    int          mode_writes  = 0;
    int          kind_seen[4] = '{0, 0, 0, 0};
    int          idle_cycles  = 0;
    int          tx_gap       = 0;
    int          rx_stall     = 0;
    bit          tx_burst     = 1'b0;
    bit          rx_burst     = 1'b0;

    // -----------------------------------------------------------------------
    // Local parser state; values match the block right after reset
    // -----------------------------------------------------------------------
    logic [1:0]  cfg_mode    = MODE_RESET;
    logic        in_payload  = 1'b0;
    logic [23:0] byte_pos    = '0;
    logic [23:0] pkt_len     = '0;
    logic [7:0]  pkt_seq     = '0;
    logic [7:0]  class_byte  = '0;
    logic [2:0]  ok_step     = '0;
    logic [3:0]  coded_left  = '0;
    logic [6:0]  coded_shift = '0;
    logic [63:0] rows_acc    = '0;
    logic [63:0] id_acc      = '0;
    logic [15:0] status_acc  = '0;
    logic [15:0] warn_acc    = '0;

    task automatic enter_ok_step(input logic [2:0] step);
        ok_step = step;
        if (step == STEP_STATUS || step == STEP_WARN) begin
            coded_left  = 4'd2;
            coded_shift = '0;
        end
    endtask

    // one byte of an OK payload past the class byte
    task automatic ok_field_byte(input logic [7:0] b);
        case (ok_step)
            STEP_ROWS_LEAD, STEP_ID_LEAD: begin
                if (b == LENC_2 || b == LENC_3 || b == LENC_8) begin
                    coded_left  = (b == LENC_2) ? 4'd2 : ((b == LENC_3) ? 4'd3 : 4'd8);
                    coded_shift = '0;
                    ok_step     = ok_step + 3'd1;
                end else begin
                    // null code and the stray 255 both read as zero
                    if (ok_step == STEP_ROWS_LEAD)
                        rows_acc = (b < LENC_NULL) ? 64'(b) : 64'd0;
                    else
                        id_acc = (b < LENC_NULL) ? 64'(b) : 64'd0;
                    enter_ok_step(ok_step + 3'd2);
                end
            end
            STEP_ROWS_EXT, STEP_ID_EXT: begin
                if (ok_step == STEP_ROWS_EXT)
                    rows_acc = rows_acc | (64'(b) << coded_shift[5:0]);
                else
                    id_acc = id_acc | (64'(b) << coded_shift[5:0]);
                coded_shift = coded_shift + 7'd8;
                if (coded_left != 0)
                    coded_left = coded_left - 4'd1;
                if (coded_left == 0)
                    enter_ok_step(ok_step + 3'd1);
            end
            STEP_STATUS, STEP_WARN: begin
                if (ok_step == STEP_STATUS)
                    status_acc = status_acc | (16'(b) << coded_shift[3:0]);
                else
                    warn_acc = warn_acc | (16'(b) << coded_shift[3:0]);
                coded_shift = coded_shift + 7'd8;
                if (coded_left != 0)
                    coded_left = coded_left - 4'd1;
                if (coded_left == 0)
                    enter_ok_step(ok_step + 3'd1);
            end
            default: begin
            end
        endcase
    endtask

    // classify the finished packet under the current mode and queue its word
    task automatic post_report();
        result_t r;
        r                 = '0;
        r.kind            = KIND_ERROR;
        r.error_code      = ERR_NONE;
        r.payload_length  = pkt_len;
        r.sequence_number = pkt_seq;
        if (class_byte == BYTE_ERR) begin
            // error class wins regardless of mode
            r.error_code = (pkt_len > MAX_PROTO_ERR_LEN) ? ERR_SERVER : ERR_PROTOCOL;
        end else if (class_byte == BYTE_OK && (cfg_mode == MODE_OK || cfg_mode == MODE_BOTH)) begin
            r.kind          = KIND_OK;
            r.rows_changed  = rows_acc;
            r.last_id       = id_acc;
            r.server_status = status_acc;
            r.warning_count = warn_acc;
        end else if (cfg_mode == MODE_DATA || cfg_mode == MODE_BOTH) begin
            if (class_byte == BYTE_EOF) begin
                r.kind          = KIND_EOF;
                r.server_status = status_acc;
                r.warning_count = warn_acc;
            end else begin
                r.kind = KIND_DATA;
            end
        end else begin
            r.error_code = ERR_EXPECT;
        end
        pending_reports.push_back(r);
    endtask

    // advance the local parse by one accepted stream byte
    task automatic parse_byte(input logic [7:0] b);
        if (!in_payload) begin
            if (byte_pos < 24'd3) begin
                if (byte_pos == 24'd0)
                    pkt_len = '0;
                pkt_len  = pkt_len | (24'(b) << (8 * byte_pos[1:0]));
                byte_pos = byte_pos + 24'd1;
            end else begin
                // sequence byte closes the header and clears the field state
                pkt_seq     = b;
                byte_pos    = '0;
                class_byte  = BYTE_OK;
                ok_step     = STEP_ROWS_LEAD;
                coded_left  = '0;
                coded_shift = '0;
                rows_acc    = '0;
                id_acc      = '0;
                status_acc  = '0;
                warn_acc    = '0;
                if (pkt_len == 24'd0) begin
                    // empty packet reports as a protocol error right away
                    class_byte = BYTE_ERR;
                    post_report();
                    class_byte = BYTE_OK;
                end else begin
                    in_payload = 1'b1;
                end
            end
        end else begin
            if (byte_pos == 24'd0) begin
                class_byte = b;
            end else if (class_byte == BYTE_OK) begin
                ok_field_byte(b);
            end else if (class_byte == BYTE_EOF) begin
                // EOF carries warnings first, then status
                case (byte_pos)
                    24'd1: warn_acc = 16'(b);
                    24'd2: warn_acc = warn_acc | (16'(b) << 8);
                    24'd3: status_acc = 16'(b);
                    24'd4: status_acc = status_acc | (16'(b) << 8);
                    default: begin
                    end
                endcase
            end
            byte_pos = byte_pos + 24'd1;
            if (byte_pos == pkt_len) begin
                post_report();
                in_payload = 1'b0;
                byte_pos   = '0;
            end
        end
    endtask

    // -----------------------------------------------------------------------
    // Packet building
    // -----------------------------------------------------------------------
    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // header (little-endian length, sequence) plus the payload in pkt
    task automatic send_packet(input logic [7:0] seq);
        logic [23:0] len;
        len = 24'(pkt.size());
        stream_bytes.push_back(len[7:0]);
        stream_bytes.push_back(len[15:8]);
        stream_bytes.push_back(len[23:16]);
        stream_bytes.push_back(seq);
        foreach (pkt[i])
            stream_bytes.push_back(pkt[i]);
        bytes_queued += 4 + pkt.size();
    endtask

    // append one length-coded integer; saturate picks the largest value
    task automatic add_coded(input int form, input bit saturate);
        int extra;
        extra = 0;
        case (form)
            CODE_DIRECT: pkt.push_back(saturate ? 8'd250 : 8'($urandom_range(0, 250)));
            CODE_NULL:   pkt.push_back(LENC_NULL);
            CODE_UNUSED: pkt.push_back(BYTE_ERR);
            CODE_TWO: begin
                pkt.push_back(LENC_2);
                extra = 2;
            end
            CODE_THREE: begin
                pkt.push_back(LENC_3);
                extra = 3;
            end
            default: begin
                pkt.push_back(LENC_8);
                extra = 8;
            end
        endcase
        repeat (extra)
            pkt.push_back(saturate ? 8'hFF : rand_byte());
    endtask

    task automatic build_ok(input int rows_form, input int id_form, input bit saturate);
        pkt.delete();
        pkt.push_back(BYTE_OK);
        add_coded(rows_form, saturate);
        add_coded(id_form, saturate);
        repeat (4)
            pkt.push_back(saturate ? 8'hFF : rand_byte());
    endtask

    task automatic build_eof();
        pkt.delete();
        pkt.push_back(BYTE_EOF);
        repeat (4)
            pkt.push_back(rand_byte());
    endtask

    // cut short or pad out an OK/EOF payload now and then
    task automatic reshape_payload();
        int keep;
        if ($urandom_range(0, 99) < 20) begin
            keep = $urandom_range(1, pkt.size());
            while (pkt.size() > keep)
                void'(pkt.pop_back());
        end else if ($urandom_range(0, 99) < 18) begin
            repeat ($urandom_range(1, 6))
                pkt.push_back(rand_byte());
        end
    endtask

    task automatic build_fill(input logic [7:0] lead, input int len);
        pkt.delete();
        pkt.push_back(lead);
        repeat (len - 1)
            pkt.push_back(rand_byte());
    endtask

    task automatic run_random(input int target);
        int start_count;
        int pick;
        int lead_pick;
        start_count = bytes_queued;
        while (bytes_queued - start_count < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                build_ok($urandom_range(CODE_DIRECT, CODE_EIGHT),
                         $urandom_range(CODE_DIRECT, CODE_EIGHT), 1'b0);
                reshape_payload();
            end else if (pick < 50) begin
                build_eof();
                reshape_payload();
            end else if (pick < 65) begin
                build_fill(8'($urandom_range(1, 253)), $urandom_range(1, 24));
            end else if (pick < 75) begin
                // protocol error up to 3 bytes, server error beyond
                build_fill(BYTE_ERR, $urandom_range(0, 1) ? $urandom_range(1, 3)
                                                          : $urandom_range(4, 16));
            end else if (pick < 80) begin
                pkt.delete();
            end else begin
                // random content, class byte leaning toward the special ones
                lead_pick = $urandom_range(0, 3);
                build_fill((lead_pick == 0) ? BYTE_OK : (lead_pick == 1) ? BYTE_EOF :
                           (lead_pick == 2) ? BYTE_ERR : rand_byte(),
                           $urandom_range(1, 14));
            end
            send_packet(rand_byte());
        end
    endtask

    // wait for the stream to drain and every word to come back
    task automatic settle();
        while (stream_bytes.size() != 0 || s_valid || pending_reports.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // APB write of expect_mode, then a read back with psel held
    task automatic set_expect_mode(input logic [1:0] mode);
        @(posedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= EXPECT_MODE_ADDR;
        pwdata  <= 32'(mode);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        cfg_mode = mode;
        mode_writes++;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata[1:0] !== mode) begin
            $error("expect_mode read back: expected %0h, got %0h", mode, prdata[1:0]);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic cmp_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // -----------------------------------------------------------------------
    // Driver: presents queued bytes, with a random gap after each word
    // -----------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                parse_byte(s_in_byte);
                bytes_taken++;
            end
            // slot is free when nothing is shown or the shown word just went
            if (!s_valid || s_ready) begin
                if (tx_gap != 0) begin
                    s_valid <= 1'b0;
                    tx_gap--;
                end else if (stream_bytes.size() != 0) begin
                    s_valid   <= 1'b1;
                    s_in_byte <= stream_bytes.pop_front();
                    if ($urandom_range(0, 39) == 0)
                        tx_burst = !tx_burst;
                    tx_gap = tx_burst ? 0 : $urandom_range(0, 7);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Monitor: checks each result word, then stalls a random while
    // -----------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                reports_seen++;
                kind_seen[m_kind]++;
                if (pending_reports.size() == 0) begin
                    $error("result word with no packet outstanding (seq %0h)",
                           m_sequence_number);
                    fail_count++;
                end else begin
                    want_report = pending_reports.pop_front();
                    cmp_field("kind", 64'(want_report.kind), 64'(m_kind));
                    cmp_field("error_code", 64'(want_report.error_code),
                              64'(m_error_code));
                    cmp_field("payload_length", 64'(want_report.payload_length),
                              64'(m_payload_length));
                    cmp_field("sequence_number", 64'(want_report.sequence_number),
                              64'(m_sequence_number));
                    cmp_field("rows_changed", want_report.rows_changed, m_rows_changed);
                    cmp_field("last_id", want_report.last_id, m_last_id);
                    cmp_field("server_status", 64'(want_report.server_status),
                              64'(m_server_status));
                    cmp_field("warning_count", 64'(want_report.warning_count),
                              64'(m_warning_count));
                end
                if ($urandom_range(0, 19) == 0)
                    rx_burst = !rx_burst;
                rx_stall = rx_burst ? 0 : $urandom_range(0, 7);
            end
            if (rx_stall != 0) begin
                m_ready <= 1'b0;
                rx_stall--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Watchdog: too long without any word moving or any register access
    // -----------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no traffic for %0d cycles, %0d results outstanding",
                         idle_cycles, pending_reports.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus
    // -----------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed packets under the reset mode (OK and data both allowed)
        pkt.delete();
        send_packet(8'hFF);                           // empty packet
        build_fill(BYTE_ERR, 1);
        send_packet(8'h00);                           // protocol error, shortest
        build_fill(BYTE_ERR, 3);
        send_packet(8'h01);                           // protocol error, longest
        build_fill(BYTE_ERR, 4);
        send_packet(8'h02);                           // server error
        build_ok(CODE_EIGHT, CODE_EIGHT, 1'b1);
        send_packet(8'h03);                           // all fields at their maximum
        build_ok(CODE_DIRECT, CODE_DIRECT, 1'b1);
        send_packet(8'h04);                           // largest one-byte values
        build_ok(CODE_NULL, CODE_UNUSED, 1'b0);
        send_packet(8'h05);                           // both codes read as zero
        build_ok(CODE_TWO, CODE_THREE, 1'b0);
        pkt.push_back(8'hA5);
        pkt.push_back(8'h5A);
        send_packet(8'h06);                           // trailing bytes ignored
        build_fill(BYTE_OK, 1);
        send_packet(8'h07);                           // OK with no fields
        pkt.delete();
        pkt.push_back(BYTE_OK);
        pkt.push_back(LENC_2);
        pkt.push_back(8'h12);
        send_packet(8'h08);                           // cut inside a coded field
        build_eof();
        send_packet(8'h09);
        build_fill(BYTE_EOF, 2);
        send_packet(8'h0A);                           // short EOF
        build_fill(8'h80, 1);
        send_packet(8'h0B);                           // one-byte data packet
        run_random(280);
        settle();

        set_expect_mode(MODE_OK);
        run_random(220);
        settle();

        set_expect_mode(MODE_DATA);
        run_random(220);
        settle();

        set_expect_mode(MODE_INVALID);
        run_random(160);
        settle();

        // two-byte length: one long data packet, the rest as usual
        set_expect_mode(MODE_BOTH);
        build_fill(8'($urandom_range(1, 253)), $urandom_range(256, 520));
        send_packet(rand_byte());
        run_random(220);
        settle();

        set_expect_mode(2'($urandom_range(0, 3)));
        run_random(180);
        settle();

        $display("%0d stream bytes in, %0d result words checked over %0d mode settings",
                 bytes_taken, reports_seen, mode_writes + 1);
        $display("  results by class: ok %0d, eof %0d, data %0d, error %0d",
                 kind_seen[KIND_OK], kind_seen[KIND_EOF], kind_seen[KIND_DATA],
                 kind_seen[KIND_ERROR]);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+design
design/dbrpp_pkg.sv
design/dbrpp_parser.sv
design/db_response_packet_parser.sv
verif/db_response_packet_parser_test.sv
